FILE: rtl/core/kpsd_pkg.sv
package kpsd_pkg;

    // Fixed shape of the key map and of the item fields
    localparam int MAP_ROWS  = 4;
    localparam int MAP_COLS  = 4;
    localparam int COL_W     = 4;
    localparam int CODE_W    = 8;
    localparam int ROWIDX_W  = 2;
    localparam int THR_W     = 3;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    localparam int DEF_NUM_ROWS = 4;
    localparam int DEF_NUM_COLS = 4;

    localparam logic             PULL_UP_RST = 1'b1;
    localparam logic [THR_W-1:0] THR_RST     = 3'd5;

    typedef logic [CODE_W-1:0]               t_code;
    typedef logic [MAP_ROWS-1:0][CFG_W-1:0]  t_key_map;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PULL_UP   = 3'd0,
        CFG_THRESHOLD = 3'd1,
        CFG_MAP_ROW0  = 3'd2,
        CFG_MAP_ROW1  = 3'd3,
        CFG_MAP_ROW2  = 3'd4,
        CFG_MAP_ROW3  = 3'd5
    } t_cfg_reg;

endpackage

FILE: rtl/core/kpsd_in_if.sv
interface kpsd_in_if;
    import kpsd_pkg::*;

    logic             valid;
    logic             ready;
    logic [COL_W-1:0] col_levels;

    modport source (output valid, output col_levels, input ready);
    modport sink   (input valid, input col_levels, output ready);
endinterface

FILE: rtl/core/kpsd_out_if.sv
interface kpsd_out_if;
    import kpsd_pkg::*;

    logic                valid;
    logic                ready;
    logic [ROWIDX_W-1:0] row_index;
    logic [CODE_W-1:0]   stable_key;
    logic                scan_complete;

    modport source (output valid, output row_index, output stable_key,
                    output scan_complete, input ready);
    modport sink   (input valid, input row_index, input stable_key,
                    input scan_complete, output ready);
endinterface

FILE: rtl/core/matrix_keypad_scan_debounce.sv
// Matrix keypad scanner with debounce.
//
// i_key carries one scan tick per item: the column levels sampled while the
// current row is driven. o_scan returns one item per tick: the row to drive
// for the next sample, the debounced key code (0 = no key) and a flag that
// marks the tick closing a full scan of all rows.
// The configuration port writes pull-up mode, debounce threshold and the four
// key map rows (one byte per column); write only while the block is idle.
// Each accepted tick's result is registered and shown in the cycle after it
// is accepted. Throughput is one tick per cycle while the receiver takes each
// result; the single result register sits at the output, all decode and counter logic sits in front of it.
// When the receiver stalls, the result is held and i_key.ready drops until
// it is taken; a new tick is accepted in the same cycle the old result goes.
// Reset (synchronous, active low) returns row to 0, clears candidates,
// counter and stable key, sets pull-up mode and a threshold of 5, clears the
// key map and empties the result register.
module matrix_keypad_scan_debounce #(
    parameter int NUM_ROWS = kpsd_pkg::DEF_NUM_ROWS,
    parameter int NUM_COLS = kpsd_pkg::DEF_NUM_COLS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [kpsd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [kpsd_pkg::CFG_W-1:0]     i_cfg_wdata,
    kpsd_in_if.sink                        i_key,
    kpsd_out_if.source                     o_scan
);
    import kpsd_pkg::*;

    localparam int ROW_W = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(NUM_ROWS - 1);

    // configuration
    logic             r_pull_up;
    logic [THR_W-1:0] r_thr;
    t_key_map         r_key_map;

    // scan state
    logic [ROW_W-1:0] r_row,  n_row;
    t_code            r_cand, n_cand;
    t_code            r_prev, n_prev;
    logic [THR_W-1:0] r_cnt,  n_cnt;
    t_code            r_held, n_held;
    logic             n_done;

    // result register
    logic                r_out_valid;
    logic [ROWIDX_W-1:0] r_out_row;
    t_code               r_out_key;
    logic                r_out_done;

    logic             accept;
    logic             row_last;
    t_code            key_code;
    t_code            cand_pick;
    logic             cand_match;
    logic [THR_W-1:0] cnt_inc;
    logic [ROW_W+1:0] n_row_ext;

    assign i_key.ready = !r_out_valid || o_scan.ready;
    assign accept      = i_key.valid && i_key.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pull_up <= PULL_UP_RST;
            r_thr     <= THR_RST;
            r_key_map <= '0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_PULL_UP:   r_pull_up    <= i_cfg_wdata[0];
                CFG_THRESHOLD: r_thr        <= i_cfg_wdata[THR_W-1:0];
                CFG_MAP_ROW0:  r_key_map[0] <= i_cfg_wdata;
                CFG_MAP_ROW1:  r_key_map[1] <= i_cfg_wdata;
                CFG_MAP_ROW2:  r_key_map[2] <= i_cfg_wdata;
                CFG_MAP_ROW3:  r_key_map[3] <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    kpsd_key_decode #(
        .NUM_COLS (NUM_COLS),
        .ROW_W    (ROW_W)
    ) u_key_decode (
        .i_levels  (i_key.col_levels),
        .i_pull_up (r_pull_up),
        .i_row     (r_row),
        .i_key_map (r_key_map),
        .o_code    (key_code)
    );

    assign cand_pick  = (key_code != '0) ? key_code : r_cand;
    assign row_last   = (r_row == LAST_ROW);
    assign cand_match = (cand_pick == r_prev) && (cand_pick != '0);
    assign cnt_inc    = (r_cnt < r_thr) ? r_cnt + 1'b1 : r_cnt;

    always_comb begin
        n_row  = r_row;
        n_cand = r_cand;
        n_prev = r_prev;
        n_cnt  = r_cnt;
        n_held = r_held;
        n_done = 1'b0;
        if (row_last) begin
            // close the full scan and judge the candidate
            n_row  = '0;
            n_done = 1'b1;
            n_prev = cand_pick;
            n_cand = '0;
            if (cand_match) begin
                n_cnt = cnt_inc;
                if (cnt_inc == r_thr) begin
                    n_held = cand_pick;
                end
            end else begin
                n_cnt = '0;
                if (cand_pick == '0) begin
                    n_held = '0;
                end
            end
        end else begin
            n_row  = r_row + 1'b1;
            n_cand = cand_pick;
        end
    end

    assign n_row_ext = {2'b00, n_row};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_cand <= '0;
            r_prev <= '0;
            r_cnt  <= '0;
            r_held <= '0;
        end else if (accept) begin
            r_row  <= n_row;
            r_cand <= n_cand;
            r_prev <= n_prev;
            r_cnt  <= n_cnt;
            r_held <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_scan.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_row  <= n_row_ext[ROWIDX_W-1:0];
            r_out_key  <= n_held;
            r_out_done <= n_done;
        end
    end

    assign o_scan.valid         = r_out_valid;
    assign o_scan.row_index     = r_out_row;
    assign o_scan.stable_key    = r_out_key;
    assign o_scan.scan_complete = r_out_done;

    a_wrap_clears_cand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && row_last |=> (r_row == '0) && (r_cand == '0))
        else $error("row or candidate not cleared after a full scan");

    a_done_row_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_scan.valid && o_scan.scan_complete |-> (o_scan.row_index == '0))
        else $error("full scan reported with a nonzero next row");

    a_stall_holds_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_key.ready |-> o_scan.valid && !o_scan.ready)
        else $error("tick refused without a stalled result");

    a_held_from_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && row_last && cand_match && (cnt_inc == r_thr)
            |=> (r_held == r_prev))
        else $error("stable key differs from the judged candidate");

endmodule

FILE: rtl/core/kpsd_key_decode.sv
module kpsd_key_decode #(
    parameter int NUM_COLS = kpsd_pkg::DEF_NUM_COLS,
    parameter int ROW_W    = 2
) (
    input  logic [kpsd_pkg::COL_W-1:0] i_levels,
    input  logic                       i_pull_up,
    input  logic [ROW_W-1:0]           i_row,
    input  kpsd_pkg::t_key_map         i_key_map,
    output kpsd_pkg::t_code            o_code
);
    import kpsd_pkg::*;

    localparam int SCAN_COLS = (NUM_COLS < MAP_COLS) ? NUM_COLS : MAP_COLS;

    logic [ROW_W+1:0]  row_ext;
    logic              row_in_map;
    logic [CFG_W-1:0]  row_codes;
    logic [COL_W-1:0]  pressed;

    assign row_ext    = {2'b00, i_row};
    assign row_in_map = row_ext < (ROW_W+2)'(MAP_ROWS);
    assign row_codes  = row_in_map ? i_key_map[row_ext[1:0]] : '0;

    always_comb begin
        for (int c = 0; c < COL_W; c++) begin
            if (c < SCAN_COLS) begin
                pressed[c] = i_pull_up ? ~i_levels[c] : i_levels[c];
            end else begin
                pressed[c] = 1'b0;
            end
        end
    end

    // Walk from the top column down so the lowest pressed column wins
    always_comb begin
        o_code = '0;
        for (int c = COL_W - 1; c >= 0; c--) begin
            if (pressed[c]) begin
                o_code = row_codes[CODE_W*c +: CODE_W];
            end
        end
    end

endmodule
